[rtl/ssd_pkg.sv]
// Package for the seismic sample converter: format codes, stage structs.
// No dependencies.
package ssd_pkg;

  typedef enum logic [4:0] {
    FMT_IBM = 5'd1, FMT_S32 = 5'd2, FMT_S16 = 5'd3, FMT_F32 = 5'd5,
    FMT_F64 = 5'd6, FMT_S24 = 5'd7, FMT_S8 = 5'd8, FMT_S64 = 5'd9,
    FMT_U32 = 5'd10, FMT_U16 = 5'd11, FMT_U64 = 5'd12, FMT_U24 = 5'd15,
    FMT_U8 = 5'd16
  } fmt_t;

  localparam logic [0:0] REG_FORMAT = 1'b0;
  localparam logic [0:0] REG_ORDER  = 1'b1;

  typedef enum logic [1:0] {
    K_ZERO = 2'd0, K_PASS = 2'd1, K_NORM = 2'd2
  } kind_t;

  // stage 1 -> 2: magnitude to normalize, or finished bits
  typedef struct packed {
    kind_t       kind;
    logic        sign;
    logic [63:0] mag;     // magnitude (normalize) or result (pass)
    logic [11:0] ebase;   // biased exponent for top bit at position 0
    logic        round;   // integer path: round to nearest even
    logic        bad;
  } s1_t;

  // stage 2 -> 3
  typedef struct packed {
    kind_t       kind;
    logic        sign;
    logic [63:0] mag;     // left-justified: top bit at 63 for NORM
    logic [11:0] expo;
    logic        round;
    logic        bad;
  } s2_t;

endpackage

[rtl/ssd_decode.sv]
// Stage 1: byte gather and format decode.
// Depends on ssd_pkg.
module ssd_decode (
  input  logic         [63:0] raw,
  input  logic         [4:0]  sample_fmt,
  input  logic                byte_order,
  output ssd_pkg::s1_t        d
);
  import ssd_pkg::*;

  function automatic logic [63:0] gather(input logic [63:0] r, input int n, input logic le);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        if (le) v[8*i +: 8] = r[8*i +: 8];
        else v[8*(n-1-i) +: 8] = r[8*i +: 8];
      end
    end
    return v;
  endfunction

  logic [63:0] g1, g2, g3, g4, g8, v;
  logic        neg;

  always_comb begin
    g1 = gather(raw, 1, byte_order);
    g2 = gather(raw, 2, byte_order);
    g3 = gather(raw, 3, byte_order);
    g4 = gather(raw, 4, byte_order);
    g8 = gather(raw, 8, byte_order);
    d = '0;
    d.kind = K_NORM;
    d.ebase = 12'd1023;
    d.round = 1'b1;
    v = '0;
    neg = 1'b0;
    unique case (sample_fmt)
      FMT_IBM: begin
        d.sign = g4[31];
        d.mag = {40'd0, g4[23:0]};
        d.round = 1'b0;
        // value = f * 2^(4e-280); biased = 4e + 743 + p
        d.ebase = {3'd0, g4[30:24], 2'b00} + 12'd743;
        if (g4[23:0] == '0) d.kind = K_ZERO;
      end
      FMT_F32: begin
        d.sign = g4[31];
        d.round = 1'b0;
        if (g4[30:23] == 8'hff) begin
          d.kind = K_PASS;
          d.mag = {g4[31], 11'h7ff, (g4[22:0] != '0), g4[21:0], 29'd0};
        end else if (g4[30:23] == 8'h00) begin
          d.mag = {41'd0, g4[22:0]};
          d.ebase = 12'd874;
          if (g4[22:0] == '0) d.kind = K_ZERO;
        end else begin
          d.kind = K_PASS;
          d.mag = {g4[31], {3'd0, g4[30:23]} + 11'd896, g4[22:0], 29'd0};
        end
      end
      FMT_F64: begin
        d.kind = K_PASS;
        d.round = 1'b0;
        d.mag = g8;
      end
      FMT_S8:  begin neg = g1[7];  v = neg ? {{56{1'b1}}, g1[7:0]}  : g1; end
      FMT_S16: begin neg = g2[15]; v = neg ? {{48{1'b1}}, g2[15:0]} : g2; end
      FMT_S24: begin neg = g3[23]; v = neg ? {{40{1'b1}}, g3[23:0]} : g3; end
      FMT_S32: begin neg = g4[31]; v = neg ? {{32{1'b1}}, g4[31:0]} : g4; end
      FMT_S64: begin neg = g8[63]; v = g8; end
      FMT_U8:  v = g1;
      FMT_U16: v = g2;
      FMT_U24: v = g3;
      FMT_U32: v = g4;
      FMT_U64: v = g8;
      default: begin
        d.kind = K_PASS;
        d.round = 1'b0;
        d.bad = 1'b1;
      end
    endcase
    if (d.round) begin
      d.sign = neg;
      d.mag = neg ? (64'd0 - v) : v;
      if (d.mag == '0) begin
        d.kind = K_ZERO;
        d.sign = 1'b0;
      end
    end
  end
endmodule

[rtl/ssd_norm.sv]
// Stage 2: leading-one normalization (left justify, exponent adjust).
// Depends on ssd_pkg.
module ssd_norm (
  input  ssd_pkg::s1_t d,
  output ssd_pkg::s2_t n
);
  import ssd_pkg::*;

  logic [5:0]  p;
  logic [63:0] m;

  always_comb begin
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (d.mag[i]) p = 6'(i);
    end
    m = d.mag << (6'd63 - p);
    n.kind = d.kind;
    n.sign = d.sign;
    n.round = d.round;
    n.bad = d.bad;
    n.mag = (d.kind == K_NORM) ? m : d.mag;
    n.expo = d.ebase + {6'd0, p};
  end
endmodule

[rtl/ssd_pack.sv]
// Stage 3: rounding and binary64 packing.
// Depends on ssd_pkg.
module ssd_pack (
  input  ssd_pkg::s2_t n,
  output logic  [63:0] bits
);
  import ssd_pkg::*;

  logic [52:0] keep;
  logic        up;
  logic [63:0] sum;

  always_comb begin
    // top bit at 63: keep bits 63:11, guard at 10, sticky below
    up = n.round && n.mag[10] && ((n.mag[9:0] != '0) || n.mag[11]);
    keep = n.mag[63:11];
    sum = {1'b0, n.expo[10:0] - 11'd1, 52'd0} + {11'd0, keep} + {63'd0, up};
    unique case (n.kind)
      K_ZERO:  bits = {n.sign, 63'd0};
      K_PASS:  bits = n.bad ? 64'd0 : n.mag;
      K_NORM:  bits = {n.sign, sum[62:0]};
      default: bits = 64'd0;
    endcase
  end
endmodule

[rtl/seismic_sample_to_double_core.sv]
// Seismic sample converter, top level: config registers and pipeline.
// Depends on ssd_pkg, ssd_decode, ssd_norm, ssd_pack.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//    the sample format code (5 bits), index 1 is byte_order.
//    cfg_ready is always high; write only while the pipe is empty.
//  - Input channel (in_valid/in_ready, sample_bytes): one raw sample per
//    transfer, first file byte in bits 7:0.
//  - Output channel (out_valid/out_ready, double_bits, format_unsupported).
//  - Three register stages: decode/gather, leading-one normalize, round and
//    pack. The valid flags v1, v2, v3 follow them, and v3 is out_valid;
//    throughput is one sample per cycle while the receiver does not stall,
//    set by the stage registers.
//  - When the receiver stalls, the whole pipe holds; in_ready drops only if
//    the last stage is full and not taken, so nothing is lost or repeated.
//  - Reset (rst, synchronous) empties the pipe and sets the format code to
//    1 (IBM float) and byte_order to 0 (big-endian).
module seismic_sample_to_double_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] sample_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] double_bits,
  output logic        format_unsupported
);
  import ssd_pkg::*;

  logic [4:0]  sample_fmt;
  logic        byte_order;
  logic        v1, v2, v3;
  s1_t         s1, s1_d;
  s2_t         s2, s2_d;
  logic [63:0] res, res_d;
  logic        bad3;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv = !v3 || out_ready;   // pipe moves as one
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_fmt <= FMT_IBM;
      byte_order <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FORMAT) sample_fmt <= cfg_data[4:0];
      else byte_order <= cfg_data[0];
    end
  end

  ssd_decode u_dec (.raw(sample_bytes), .sample_fmt(sample_fmt),
                    .byte_order(byte_order), .d(s1_d));
  ssd_norm   u_norm (.d(s1), .n(s2_d));
  ssd_pack   u_pack (.n(s2), .bits(res_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= s1_d;
      s2   <= s2_d;
      res  <= res_d;
      bad3 <= s2.bad;
    end
  end

  assign out_valid = v3;
  assign double_bits = res;
  assign format_unsupported = bad3;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(double_bits))
    else $error("output changed under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted item lost at stage 1");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_unsupported |-> double_bits == 64'd0)
    else $error("unsupported format with nonzero result");
`endif
endmodule

[sim/seismic_sample_to_double_core_tb.sv]
// Testbench for seismic_sample_to_double_core: directed and random samples
// across every format code and byte order, checked against an in-bench model.
// Depends on ssd_pkg and the core RTL.
`timescale 1ns / 1ps

module seismic_sample_to_double_core_tb;
  import ssd_pkg::*;

  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam int PIPE_CYCLES = 3;

  typedef struct packed {
    logic [63:0] bits;
    logic        unsupported;
  } conv_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] sample_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] double_bits;
  logic        format_unsupported;

  // bench copy of the config registers
  logic [4:0] cur_format;
  logic       cur_little;

  conv_t expected_q[$];
  int    errors;
  int    n_sent;
  int    n_seen;

  // idle rates, percent
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;  // forced receiver hold-off, in cycles

  seismic_sample_to_double_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // bytes of the sample in file order folded into one word
  function automatic logic [63:0] gather_bytes(logic [63:0] raw, int n, logic little);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) begin
      if (little) v |= {56'd0, raw[8*i +: 8]} << (8 * i);
      else v = (v << 8) | {56'd0, raw[8*i +: 8]};
    end
    return v;
  endfunction

  function automatic int msb_pos(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // magnitude and sign to binary64, nearest even
  function automatic logic [63:0] int_to_double(logic [63:0] mag, logic neg);
    int p;
    int sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    if (mag == 0) return '0;
    p = msb_pos(mag);
    if (p <= 52) begin
      keep = mag << (52 - p);
    end else begin
      sh = p - 52;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    // hidden bit of keep carries into the exponent field
    return {neg, 63'd0} | ((64'(1022 + p) << 52) + keep);
  endfunction

  function automatic logic [63:0] ibm_to_double(logic [31:0] w);
    int p;
    logic [63:0] f;
    logic [63:0] biased;
    f = {40'd0, w[23:0]};
    if (f == 0) return {w[31], 63'd0};
    p = msb_pos(f);
    biased = 64'(p) + 4 * 64'(w[30:24]) + 743;
    return {w[31], 63'd0} | (biased << 52) | ((f << (52 - p)) & FRAC_MASK);
  endfunction

  function automatic logic [63:0] single_to_double(logic [31:0] w);
    logic [63:0] sgn;
    logic [63:0] m;
    int p;
    sgn = {w[31], 63'd0};
    m = {41'd0, w[22:0]};
    if (w[30:23] == 8'hFF) begin
      if (m == 0) return sgn | (64'h7FF << 52);
      return sgn | (64'h7FF << 52) | QUIET_BIT | (m << 29);
    end
    if (w[30:23] == 0) begin
      if (m == 0) return sgn;
      p = msb_pos(m);
      return sgn | (64'(p + 874) << 52) | ((m << (52 - p)) & FRAC_MASK);
    end
    return sgn | ((64'(w[30:23]) + 896) << 52) | (m << 29);
  endfunction

  function automatic conv_t convert_sample(logic [63:0] raw);
    conv_t r;
    logic [63:0] v;
    r = '0;
    case (cur_format)
      FMT_IBM: r.bits = ibm_to_double(32'(gather_bytes(raw, 4, cur_little)));
      FMT_S32: begin
        v = gather_bytes(raw, 4, cur_little);
        r.bits = v[31] ? int_to_double(64'h1_0000_0000 - v, 1'b1) : int_to_double(v, 1'b0);
      end
      FMT_S16: begin
        v = gather_bytes(raw, 2, cur_little);
        r.bits = v[15] ? int_to_double(64'h1_0000 - v, 1'b1) : int_to_double(v, 1'b0);
      end
      FMT_F32: r.bits = single_to_double(32'(gather_bytes(raw, 4, cur_little)));
      FMT_F64: r.bits = gather_bytes(raw, 8, cur_little);
      FMT_S24: begin
        v = gather_bytes(raw, 3, cur_little);
        r.bits = v[23] ? int_to_double(64'h100_0000 - v, 1'b1) : int_to_double(v, 1'b0);
      end
      FMT_S8: begin
        v = gather_bytes(raw, 1, cur_little);
        r.bits = v[7] ? int_to_double(64'h100 - v, 1'b1) : int_to_double(v, 1'b0);
      end
      FMT_S64: begin
        v = gather_bytes(raw, 8, cur_little);
        r.bits = v[63] ? int_to_double(64'd0 - v, 1'b1) : int_to_double(v, 1'b0);
      end
      FMT_U32: r.bits = int_to_double(gather_bytes(raw, 4, cur_little), 1'b0);
      FMT_U16: r.bits = int_to_double(gather_bytes(raw, 2, cur_little), 1'b0);
      FMT_U64: r.bits = int_to_double(gather_bytes(raw, 8, cur_little), 1'b0);
      FMT_U24: r.bits = int_to_double(gather_bytes(raw, 3, cur_little), 1'b0);
      FMT_U8:  r.bits = int_to_double(gather_bytes(raw, 1, cur_little), 1'b0);
      default: r.unsupported = 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // one config write; only called with the pipe empty
  task automatic write_reg(logic idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FORMAT) cur_format = data[4:0];
    else cur_little = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic [63:0] fmt, logic little);
    drain();
    write_reg(REG_FORMAT, fmt);
    write_reg(REG_ORDER, {63'd0, little});
  endtask

  // one input transfer; valid stays up across back-to-back samples
  task automatic send_sample(logic [63:0] raw);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_bytes <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q = {expected_q, convert_sample(raw)};
    n_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every expected result, then let the pipe settle
  task automatic drain();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 2) @(posedge clk);
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    conv_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result bits=%h unsupported=%b",
                 $time, double_bits, format_unsupported);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (double_bits !== exp_r.bits) begin
          $display("%0t: double_bits mismatch expected %h actual %h",
                   $time, exp_r.bits, double_bits);
          errors++;
        end
        if (format_unsupported !== exp_r.unsupported) begin
          $display("%0t: format_unsupported mismatch expected %b actual %b",
                   $time, exp_r.unsupported, format_unsupported);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset values: IBM, big-endian, before any write
  task automatic test_reset_defaults();
    send_sample(64'h0000_0000_0000_0041);  // bytes 41 00 00 00 -> zero fraction
    send_sample(64'hFFFF_FFFF_0000_1042);
    send_sample(64'h0000_0000_0100_00C1);  // negative
    drain();
  endtask

  // IBM extremes and signed zero
  task automatic test_ibm_edges();
    set_mode(64'(FMT_IBM), 1'b0);
    send_sample(64'h0000_0000_FFFF_FF7F);  // largest
    send_sample(64'h0000_0000_0100_0000);  // smallest exponent
    send_sample(64'h0000_0000_0000_0080);  // negative zero
    send_sample(64'h0000_0000_0000_00FF);  // zero fraction, max exponent
    set_mode(64'(FMT_IBM), 1'b1);
    send_sample(64'h0000_0000_4110_0000);
    drain();
  endtask

  // IEEE single: subnormal, infinity, NaN payload; double pass-through
  task automatic test_ieee_specials();
    set_mode(64'(FMT_F32), 1'b1);
    send_sample(64'h0000_0000_0000_0001);  // smallest subnormal
    send_sample(64'h0000_0000_807F_FFFF);  // negative subnormal
    send_sample(64'h0000_0000_7F80_0000);  // +inf
    send_sample(64'h0000_0000_FF80_0000);  // -inf
    send_sample(64'h0000_0000_7F80_0001);  // signaling NaN, gets quiet bit
    send_sample(64'h0000_0000_8000_0000);  // -0
    set_mode(64'(FMT_F64), 1'b0);
    send_sample(64'h0100_0000_0000_F07F);  // NaN passes untouched
    drain();
  endtask

  // integer extremes, 24-bit in both orders, 64-bit rounding ties
  task automatic test_integer_edges();
    set_mode(64'(FMT_S24), 1'b0);
    send_sample(64'h0000_0000_0000_0080);  // most negative
    send_sample(64'h0000_0000_00FF_FF7F);  // most positive
    set_mode(64'(FMT_S24), 1'b1);
    send_sample(64'h0000_0000_0080_0000);
    set_mode(64'(FMT_S64), 1'b1);
    send_sample(64'h8000_0000_0000_0000);
    send_sample(64'h0020_0000_0000_0001);  // exact tie above 2^53
    send_sample(64'h0020_0000_0000_0003);  // tie rounds up to even
    set_mode(64'(FMT_U64), 1'b1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF);  // rounds to 2^64
    send_sample(64'h0);                    // integer zero
    drain();
  endtask

  // codes with no conversion, and oversized write data
  task automatic test_unsupported();
    logic [4:0] bad_codes[5] = '{5'd0, 5'd4, 5'd13, 5'd14, 5'd31};
    foreach (bad_codes[i]) begin
      set_mode({59'h1FF, bad_codes[i]}, 1'b0);
      send_sample({$urandom, $urandom});
    end
    drain();
  endtask

  // random samples over random formats, per idling scheme
  task automatic test_random(int n_items, int s_pct, int r_pct);
    logic [63:0] raw;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) begin
        drain();
        set_mode({$urandom, $urandom_range(16, 0)}, 1'($urandom_range(1, 0)));
      end
      raw = {$urandom, $urandom};
      // some samples are special patterns rather than uniform bytes
      case ($urandom_range(5, 0))
        0: raw = '0;
        1: raw = '1;
        2: raw = raw & 64'h0000_0000_0000_00FF;
        default: ;
      endcase
      send_sample(raw);
    end
    drain();
  endtask

  // receiver holds off long enough for the pipe to back up into in_ready
  task automatic test_backpressure();
    set_mode(64'(FMT_S16), 1'b1);
    send_idle_pct = 0;
    recv_hold = 40;
    for (int i = 0; i < 20; i++) send_sample({$urandom, $urandom});
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_bytes = '0;
    cur_format = FMT_IBM;
    cur_little = 1'b0;
    errors = 0;
    n_sent = 0;
    n_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_ibm_edges();
    test_ieee_specials();
    test_integer_edges();
    test_unsupported();
    test_random(150, 38, 47);
    test_random(150, 47, 38);
    test_random(150, 0, 0);
    test_backpressure();

    $display("Sent %0d samples over all format codes and both byte orders,", n_sent);
    $display("checked %0d results with idling and receiver back-pressure.", n_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** seismic_sample_to_double_core: PASSED **");
    end else begin
      $display("** seismic_sample_to_double_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout");
    $display("** seismic_sample_to_double_core: FAILED **");
    $finish;
  end

endmodule
